[rtl/dhot_pkg.sv]
package dhot_pkg;

   localparam int MAX_SLOTS_DEF = 1024;
   localparam int KEY_BITS_DEF  = 32;
   localparam int CNT_BITS      = 11;
   localparam int HASH_BITS     = 31;
   localparam int STEP_SHIFT    = 5;
   localparam int RESP_BITS     = 10;
   localparam logic [CNT_BITS-1:0] SLOT_COUNT_RESET = 11'd1021;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_FIND   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_EMPTY   = 2'd0,
      ST_USED    = 2'd1,
      ST_REMOVED = 2'd2,
      ST_SPARE   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLEAR,
      S_DIV,
      S_READ,
      S_CHECK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] lookup_key;
      logic [31:0] hash_code;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic [RESP_BITS-1:0] slot_index;
   } rsp_type;

endpackage

[rtl/dhot_ram.sv]
module dhot_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[rtl/double_hash_open_table.sv]
// Open-addressed hash table with double hashing and tombstones. A request is
// taken when start is high and busy is low; exactly one response follows, shown
// for one cycle with rsp_valid, and the receiver cannot stall it. After reset
// the block clears every slot of its status memory, busy high. Each
// request then runs two bit-serial remainders (start slot and step, computed
// side by side), a status/key memory read and check per visited slot, a finish
// state and a registered response; a request with slot_count below 2 or opcode
// OP_NONE goes straight to the finish state. csr_wr_en writes slot_count; the
// user must assert it only while idle, as the block does not enforce this.
module double_hash_open_table
   import dhot_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF,
   parameter int KEY_BITS  = KEY_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req_data,
   output logic                rsp_valid,
   output rsp_type             rsp_data,
   input  logic                csr_wr_en,
   input  logic [CNT_BITS-1:0] csr_wr_data
);

   localparam int AW = $clog2(MAX_SLOTS);
   localparam int NW = AW + 1;
   localparam int PW = (NW > CNT_BITS) ? NW : CNT_BITS;

   state_type state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff;
   logic [PW-1:0]       n_ff, n_in;
   opcode_type          op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [HASH_BITS-1:0] qa_ff, qa_in, qb_ff, qb_in;
   logic [PW-1:0]       ra_ff, ra_in, rb_ff, rb_in;
   logic [4:0]          bit_ff, bit_in;
   logic [PW-1:0]       pos_ff, pos_in, step_ff, step_in, vis_ff, vis_in;
   logic                hit_ff, hit_in;
   logic [AW-1:0]       where_ff, where_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                st_we, key_we;
   logic [AW-1:0]       st_waddr, raddr;
   logic [1:0]          st_wdata, st_rdata;
   logic [KEY_BITS-1:0] key_rdata;

   logic [PW:0] ra_sh, rb_sh, pos_sum;
   logic [PW-1:0] n_eff;
   logic [HASH_BITS-1:0] hb;

   dhot_ram #(.WIDTH(2), .DEPTH(MAX_SLOTS)) u_status (
      .clock(clock), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(st_wdata),
      .rd_addr(raddr), .rd_data(st_rdata));

   dhot_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_SLOTS)) u_key (
      .clock(clock), .wr_en(key_we), .wr_addr(where_in), .wr_data(key_ff),
      .rd_addr(raddr), .rd_data(key_rdata));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         count_ff     <= SLOT_COUNT_RESET;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
      n_ff <= n_in; op_ff <= op_in; key_ff <= key_in;
      qa_ff <= qa_in; qb_ff <= qb_in; ra_ff <= ra_in; rb_ff <= rb_in;
      bit_ff <= bit_in; pos_ff <= pos_in; step_ff <= step_in; vis_ff <= vis_in;
      hit_ff <= hit_in; where_ff <= where_in;
   end

   always_comb begin
      if (PW'(count_ff) > PW'(MAX_SLOTS)) begin
         n_eff = PW'(MAX_SLOTS);
      end else begin
         n_eff = PW'(count_ff);
      end
      hb    = req_data.hash_code[HASH_BITS-1:0] >> STEP_SHIFT;
      ra_sh = {ra_ff, qa_ff[HASH_BITS-1]};
      rb_sh = {rb_ff, qb_ff[HASH_BITS-1]};
      pos_sum = {1'b0, pos_ff} + {1'b0, step_ff};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (clr_ff == AW'(MAX_SLOTS - 1)) state_in = S_IDLE;
         S_IDLE:  if (start) begin
            if (n_eff < PW'(2) || req_data.opcode == OP_NONE) state_in = S_DONE;
            else state_in = S_DIV;
         end
         S_DIV:   if (bit_ff == 5'd0) state_in = S_READ;
         S_READ:  state_in = S_CHECK;
         S_CHECK: begin
            if (hit_in || vis_in == n_ff || (op_ff != OP_INSERT &&
                status_type'(st_rdata) == ST_EMPTY)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_READ;
            end
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      n_in = n_ff; op_in = op_ff; key_in = key_ff;
      qa_in = qa_ff; qb_in = qb_ff; ra_in = ra_ff; rb_in = rb_ff;
      bit_in = bit_ff; pos_in = pos_ff; step_in = step_ff; vis_in = vis_ff;
      hit_in = hit_ff; where_in = where_ff;
      clr_in = clr_ff;
      st_we = 1'b0; key_we = 1'b0;
      st_waddr = where_ff; st_wdata = ST_USED;
      raddr = pos_ff[AW-1:0];
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            st_we = 1'b1; st_waddr = clr_ff; st_wdata = ST_EMPTY;
            clr_in = clr_ff + AW'(1);
         end
         S_IDLE: begin
            n_in   = n_eff;
            op_in  = opcode_type'(req_data.opcode);
            key_in = KEY_BITS'(req_data.lookup_key);
            qa_in  = req_data.hash_code[HASH_BITS-1:0];
            qb_in  = hb + HASH_BITS'(1);
            ra_in  = '0; rb_in = '0;
            bit_in = 5'(HASH_BITS - 1);
            hit_in = 1'b0; where_in = '0; vis_in = '0;
         end
         S_DIV: begin
            qa_in = {qa_ff[HASH_BITS-2:0], 1'b0};
            qb_in = {qb_ff[HASH_BITS-2:0], 1'b0};
            if (ra_sh >= {1'b0, n_ff}) ra_in = PW'(ra_sh - {1'b0, n_ff});
            else ra_in = PW'(ra_sh);
            if (rb_sh >= {1'b0, n_ff - PW'(1)}) rb_in = PW'(rb_sh - {1'b0, n_ff - PW'(1)});
            else rb_in = PW'(rb_sh);
            bit_in = bit_ff - 5'd1;
            if (bit_ff == 5'd0) begin
               pos_in  = ra_in;
               step_in = rb_in + PW'(1);
            end
         end
         S_CHECK: begin
            vis_in = vis_ff + PW'(1);
            if (pos_sum >= {1'b0, n_ff}) pos_in = PW'(pos_sum - {1'b0, n_ff});
            else pos_in = PW'(pos_sum);
            if (op_ff == OP_INSERT) begin
               if (status_type'(st_rdata) != ST_USED) begin
                  hit_in = 1'b1; where_in = pos_ff[AW-1:0];
                  st_we = 1'b1; key_we = 1'b1; st_waddr = pos_ff[AW-1:0];
                  st_wdata = ST_USED;
               end
            end else if (status_type'(st_rdata) == ST_USED && key_rdata == key_ff) begin
               hit_in = 1'b1; where_in = pos_ff[AW-1:0];
               if (op_ff == OP_REMOVE) begin
                  st_we = 1'b1; st_waddr = pos_ff[AW-1:0]; st_wdata = ST_REMOVED;
               end
            end
         end
         S_DONE: rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data.hit = hit_ff;
   assign rsp_data.slot_index = RESP_BITS'(where_ff);

   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == S_DONE)
      else $error("response without completion");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.slot_index == '0)
      else $error("miss with nonzero slot");
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !st_we && !key_we)
      else $error("memory write while idle");
   a_busy_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(busy, 2) || $past(state_ff, 2) != S_IDLE)
      else $error("response timing");

endmodule
